/* rtl/core/gtg_pkg.sv */
// Package for the go-to-goal wheel controller: widths, constants, CORDIC table, codes.
// Depends on nothing. Used by every module in rtl/core.
`timescale 1ns / 1ps
package gtg_pkg;

  localparam int FRAC_BITS = 12;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD = 8;
  // CORDIC datapath: 17-bit difference with guard bits, growth up to ~1.65*sqrt2.
  localparam int CW = 28;
  // Angle width in Q30, wide enough for +-pi plus accumulated steps.
  localparam int AW = 34;
  localparam int DIVW = 33;  // width of the dividend a*ms + m/2
  localparam int QW = 16;    // quotient bits kept

  localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [34:0] INV_GAIN_Q30 = 35'sd652032874;
  // Pi and two pi in Q12 (FRAC_BITS), rounded to nearest from their Q30 values.
  localparam logic signed [19:0] PI_Q =
    20'((64'sd3373259426 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
  localparam logic signed [19:0] TWO_PI_Q =
    20'((64'sd6746518852 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_DRIVE = 2'd1,
    ACT_HALT  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_MAX_SPEED   = 2'd0,
    REG_STEER_RATIO = 2'd1,
    REG_HALT_RADIUS = 2'd2
  } reg_idx_t;

  function automatic logic signed [AW-1:0] atan_q30(input int i);
    logic signed [AW-1:0] r;
    begin
      unique case (i)
        0: r = 34'sd843314857;
        1: r = 34'sd497837829;
        2: r = 34'sd263043837;
        3: r = 34'sd133525159;
        4: r = 34'sd67021687;
        5: r = 34'sd33543516;
        6: r = 34'sd16775851;
        7: r = 34'sd8388437;
        8: r = 34'sd4194283;
        9: r = 34'sd2097149;
        default: r = AW'(64'sd1 <<< (30 - i));
      endcase
      return r;
    end
  endfunction

  // Control group that travels through the mixer and scaler stages.
  typedef struct packed {
    logic    vld;
    action_t act;
  } ctl_t;

endpackage

/* rtl/core/gtg_if.sv */
// Valid/ready stream interfaces for the input pose, the result and config writes.
// Depends on nothing.
`timescale 1ns / 1ps
interface gtg_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  logic signed [14:0] cur_heading;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic frozen;
  modport source (output valid, cur_x, cur_y, cur_heading, target_x, target_y, frozen,
                  input ready);
  modport sink (input valid, cur_x, cur_y, cur_heading, target_x, target_y, frozen,
                output ready);
endinterface

interface gtg_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic [1:0] action;
  modport source (output valid, left_speed, right_speed, action, input ready);
  modport sink (input valid, left_speed, right_speed, action, output ready);
endinterface

interface gtg_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [14:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/gtg_cordic.sv */
// Pipelined vectoring CORDIC: pre-rotation stage then one register stage per iteration.
// Depends on gtg_pkg. Carries a payload word alongside each sample.
`timescale 1ns / 1ps
module gtg_cordic
  import gtg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [16:0]   dx,
  input  logic signed [16:0]   dy,
  input  logic [15:0]          in_tag,
  output logic                 out_vld,
  output logic signed [CW-1:0] out_x,
  output logic signed [AW-1:0] out_z,
  output logic [15:0]          out_tag
);

  logic                 vld [CORDIC_STAGES+1];
  logic signed [CW-1:0] xs  [CORDIC_STAGES+1];
  logic signed [CW-1:0] ys  [CORDIC_STAGES+1];
  logic signed [AW-1:0] zs  [CORDIC_STAGES+1];
  logic [15:0]          tag [CORDIC_STAGES+1];

  logic signed [CW-1:0] gx, gy;
  assign gx = CW'(dx) <<< GUARD;
  assign gy = CW'(dy) <<< GUARD;

  // Quadrant pre-rotation for the left half plane.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
    if (en) begin
      tag[0] <= in_tag;
      if (gx < 0) begin
        if (gy >= 0) begin
          xs[0] <= gy; ys[0] <= -gx; zs[0] <= HALF_PI_Q30;
        end else begin
          xs[0] <= -gy; ys[0] <= gx; zs[0] <= -HALF_PI_Q30;
        end
      end else begin
        xs[0] <= gx; ys[0] <= gy; zs[0] <= '0;
      end
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        tag[i+1] <= tag[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_q30(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_q30(i);
        end
      end
    end
  end

  assign out_vld = vld[CORDIC_STAGES];
  assign out_x   = xs[CORDIC_STAGES];
  assign out_z   = zs[CORDIC_STAGES];
  assign out_tag = tag[CORDIC_STAGES];

endmodule

/* rtl/core/gtg_mixer.sv */
// Distance gain, bearing wrap, steering product and wheel mix, three register stages.
// Depends on gtg_pkg.
`timescale 1ns / 1ps
module gtg_mixer
  import gtg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [CW-1:0] cx,
  input  logic signed [AW-1:0] cz,
  input  logic [15:0]          tag,
  input  logic [14:0]          steer_ratio,
  input  logic [14:0]          halt_radius,
  output ctl_t                 ctl,
  output logic signed [20:0]   wl,
  output logic signed [20:0]   wr
);

  // Stage A: gain product and bearing rounding.
  logic signed [62:0] prod_a;
  logic signed [19:0] bear_a;
  logic signed [14:0] hd_a;
  logic               frz_a, vld_a;
  logic signed [AW-1:0] zr;
  assign zr = cz + AW'(1 <<< (29 - FRAC_BITS));
  always_ff @(posedge clk) begin
    if (rst) vld_a <= 1'b0;
    else if (en) vld_a <= in_vld;
    if (en) begin
      prod_a <= 63'(cx) * 63'(INV_GAIN_Q30);
      bear_a <= 20'(zr >>> (30 - FRAC_BITS));
      hd_a   <= tag[14:0];
      frz_a  <= tag[15];
    end
  end

  // Stage B: distance rounding and wrap of the bearing error into -pi..pi.
  logic signed [62:0] pr;
  logic signed [19:0] dh0, dh_w;
  assign pr  = prod_a + 63'(64'sd1 <<< (29 + GUARD));
  assign dh0 = bear_a - 20'(hd_a);
  always_comb begin
    dh_w = dh0;
    if (dh0 > PI_Q) begin
      dh_w = dh0 - TWO_PI_Q;
      if (dh_w > PI_Q) dh_w = dh_w - TWO_PI_Q;
    end else if (dh0 < -PI_Q) begin
      dh_w = dh0 + TWO_PI_Q;
      if (dh_w < -PI_Q) dh_w = dh_w + TWO_PI_Q;
    end
  end
  logic signed [19:0] dd_b, dh_b;
  logic frz_b, vld_b;
  always_ff @(posedge clk) begin
    if (rst) vld_b <= 1'b0;
    else if (en) vld_b <= vld_a;
    if (en) begin
      dd_b  <= 20'(pr >>> (30 + GUARD));
      dh_b  <= dh_w;
      frz_b <= frz_a;
    end
  end

  // Stage C: steering product, rounded; action decision.
  logic signed [36:0] sp;
  assign sp = 37'($signed({1'b0, steer_ratio})) * 37'(dh_b) +
              37'(64'sd1 <<< (FRAC_BITS - 1));
  logic signed [19:0] dd_c, st_c;
  ctl_t ctl_c;
  always_ff @(posedge clk) begin
    if (rst) ctl_c.vld <= 1'b0;
    else if (en) ctl_c.vld <= vld_b;
    if (en) begin
      dd_c <= dd_b;
      st_c <= 20'(sp >>> FRAC_BITS);
      if (frz_b) ctl_c.act <= ACT_NONE;
      else if (dd_b > $signed({5'b0, halt_radius})) ctl_c.act <= ACT_DRIVE;
      else ctl_c.act <= ACT_HALT;
    end
  end

  assign ctl = ctl_c;
  assign wl  = 21'(dd_c) - 21'(st_c);
  assign wr  = 21'(dd_c) + 21'(st_c);

endmodule

/* rtl/core/gtg_scaler.sv */
// Wheel speed normalization: pipelined restoring dividers for both wheels, one bit a stage.
// Depends on gtg_pkg.
`timescale 1ns / 1ps
module gtg_scaler
  import gtg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  ctl_t               in_ctl,
  input  logic signed [20:0] wl,
  input  logic signed [20:0] wr,
  input  logic [14:0]        max_speed,
  output ctl_t               out_ctl,
  output logic signed [15:0] left_speed,
  output logic signed [15:0] right_speed
);

  localparam int NS = DIVW;

  // Stage 0: magnitudes and their maximum.
  logic [20:0] al, ar;
  assign al = wl[20] ? 21'(-wl) : 21'(wl);
  assign ar = wr[20] ? 21'(-wr) : 21'(wr);
  ctl_t c0;
  logic [20:0] al0, ar0;
  logic sl0, sr0;
  logic [14:0] ms0;
  always_ff @(posedge clk) begin
    if (rst) c0.vld <= 1'b0;
    else if (en) c0.vld <= in_ctl.vld;
    if (en) begin
      c0.act <= in_ctl.act;
      al0 <= al; ar0 <= ar; sl0 <= wl[20]; sr0 <= wr[20];
      ms0 <= max_speed;
    end
  end
  logic [20:0] m0;
  assign m0 = (al0 > ar0) ? al0 : ar0;

  // Stage 1: dividends a*ms + m/2.
  ctl_t cs [NS+1];
  logic [DIVW-1:0] nl [NS+1], nr [NS+1];
  logic [21:0] rl [NS+1], rrm [NS+1];
  logic [20:0] dv [NS+1];
  logic [14:0] mss [NS+1];
  logic sls [NS+1], srs [NS+1];
  always_ff @(posedge clk) begin
    if (rst) cs[0].vld <= 1'b0;
    else if (en) cs[0].vld <= c0.vld;
    if (en) begin
      cs[0].act <= c0.act;
      nl[0] <= DIVW'(al0 * 36'(ms0)) + DIVW'(m0 >> 1);
      nr[0] <= DIVW'(ar0 * 36'(ms0)) + DIVW'(m0 >> 1);
      rl[0] <= '0; rrm[0] <= '0;
      dv[0] <= m0; mss[0] <= ms0; sls[0] <= sl0; srs[0] <= sr0;
    end
  end

  // Restoring division, one quotient bit per stage; quotient shifts into the dividend.
  for (genvar i = 0; i < NS; i++) begin : g_div
    logic [22:0] tl, tr;
    assign tl = {rl[i], nl[i][DIVW-1]} - {2'b0, dv[i]};
    assign tr = {rrm[i], nr[i][DIVW-1]} - {2'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (rst) cs[i+1].vld <= 1'b0;
      else if (en) cs[i+1].vld <= cs[i].vld;
      if (en) begin
        cs[i+1].act <= cs[i].act;
        dv[i+1] <= dv[i]; mss[i+1] <= mss[i]; sls[i+1] <= sls[i]; srs[i+1] <= srs[i];
        if (!tl[22]) begin
          rl[i+1] <= tl[21:0]; nl[i+1] <= {nl[i][DIVW-2:0], 1'b1};
        end else begin
          rl[i+1] <= {rl[i][20:0], nl[i][DIVW-1]}; nl[i+1] <= {nl[i][DIVW-2:0], 1'b0};
        end
        if (!tr[22]) begin
          rrm[i+1] <= tr[21:0]; nr[i+1] <= {nr[i][DIVW-2:0], 1'b1};
        end else begin
          rrm[i+1] <= {rrm[i][20:0], nr[i][DIVW-1]}; nr[i+1] <= {nr[i][DIVW-2:0], 1'b0};
        end
      end
    end
  end

  // Final stage: clamp, sign and action gating into the output register.
  logic [15:0] ql, qr;
  always_comb begin
    ql = (nl[NS] > DIVW'(mss[NS])) ? {1'b0, mss[NS]} : nl[NS][15:0];
    qr = (nr[NS] > DIVW'(mss[NS])) ? {1'b0, mss[NS]} : nr[NS][15:0];
    if (dv[NS] == '0 || cs[NS].act != ACT_DRIVE) begin
      ql = '0; qr = '0;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) out_ctl.vld <= 1'b0;
    else if (en) out_ctl.vld <= cs[NS].vld;
    if (en) begin
      out_ctl.act <= cs[NS].act;
      left_speed  <= sls[NS] ? -$signed(ql) : $signed(ql);
      right_speed <= srs[NS] ? -$signed(qr) : $signed(qr);
    end
  end

  // Speeds never exceed max_speed in magnitude; non-drive results carry zero speeds.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_ctl.vld && out_ctl.act != ACT_DRIVE |-> left_speed == 0 && right_speed == 0)
    else $error("non-drive result has nonzero speed");
  a_vld: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_ctl.vld))
    else $error("output valid moved while stalled");
  a_act: assert property (@(posedge clk) disable iff (rst)
    out_ctl.vld |-> (out_ctl.act == ACT_NONE || out_ctl.act == ACT_DRIVE ||
                     out_ctl.act == ACT_HALT))
    else $error("illegal action code");

endmodule

/* rtl/core/go_to_goal_wheel_controller.sv */
// Top level of the go-to-goal wheel controller: config registers, pipeline control.
// Depends on gtg_pkg, gtg_if, gtg_cordic, gtg_mixer, gtg_scaler.
//
// Use: pose samples arrive on the in channel (valid/ready); one result
// (left_speed, right_speed, action) leaves per sample on the out channel.
// The cfg channel writes max_speed (0), steer_ratio (1) and halt_radius (2);
// it is always ready and other indexes are dropped. Write it only while idle.
// Throughput: one sample per cycle while the receiver does not stall. Between an
// input transfer and its result transfer lie the register stages: the 17
// CORDIC stages, 3 mixer stages, and in the scaler two entry stages, the 33
// stages of the bit-per-stage speed divider and the output register.
// The whole pipeline advances as one when the output register is empty or
// being taken; when the receiver stalls, every stage holds and ready drops.
// Reset clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps
module go_to_goal_wheel_controller
  import gtg_pkg::*;
(
  input logic clk,
  input logic rst,
  gtg_in_if.sink    in,
  gtg_out_if.source out,
  gtg_cfg_if.sink   cfg
);

  logic [14:0] max_speed, steer_ratio, halt_radius;

  // Configuration registers.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed   <= 15'd25723;
      steer_ratio <= 15'd5195;
      halt_radius <= 15'd41;
    end else if (cfg.valid) begin
      if (cfg.index == REG_MAX_SPEED) max_speed <= cfg.data;
      else if (cfg.index == REG_STEER_RATIO) steer_ratio <= cfg.data;
      else if (cfg.index == REG_HALT_RADIUS) halt_radius <= cfg.data;
    end
  end

  // Global pipeline enable.
  ctl_t fin;
  logic en;
  assign en = !fin.vld || out.ready;
  assign in.ready = en;

  logic signed [16:0] dx, dy;
  assign dx = 17'(in.target_x) - 17'(in.cur_x);
  assign dy = 17'(in.target_y) - 17'(in.cur_y);

  logic                 c_vld;
  logic signed [CW-1:0] c_x;
  logic signed [AW-1:0] c_z;
  logic [15:0]          c_tag;

  gtg_cordic u_cordic (
    .clk(clk), .rst(rst), .en(en), .in_vld(in.valid),
    .dx(dx), .dy(dy), .in_tag({in.frozen, in.cur_heading}),
    .out_vld(c_vld), .out_x(c_x), .out_z(c_z), .out_tag(c_tag)
  );

  ctl_t mctl;
  logic signed [20:0] wl, wr;

  gtg_mixer u_mixer (
    .clk(clk), .rst(rst), .en(en), .in_vld(c_vld), .cx(c_x), .cz(c_z),
    .tag(c_tag), .steer_ratio(steer_ratio), .halt_radius(halt_radius),
    .ctl(mctl), .wl(wl), .wr(wr)
  );

  gtg_scaler u_scaler (
    .clk(clk), .rst(rst), .en(en), .in_ctl(mctl), .wl(wl), .wr(wr),
    .max_speed(max_speed), .out_ctl(fin),
    .left_speed(out.left_speed), .right_speed(out.right_speed)
  );

  assign out.valid  = fin.vld;
  assign out.action = fin.act;

  // Ready follows the output side only.
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |-> !in.ready)
    else $error("input taken while output stalled");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.action))
    else $error("stalled result changed");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.index == REG_MAX_SPEED |=> max_speed == $past(cfg.data))
    else $error("max_speed write lost");

endmodule
